// ===== rtl/sha_pkg.sv =====
package sha_pkg;

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  valid_bytes;
        logic        is_last;
    } t_in_req;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        digest_done;
    } t_out_req;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       push;       // write push_word into the window and count a word
        logic       add_bytes;  // add the accepted request's byte count
        logic       round_init; // load working variables from the chaining state
        logic       round_step; // run one round
        logic       round_fold; // add working variables into the chaining state
        logic       msg_clear;  // restore initial hash, clear counters
        logic [2:0] push_sel;   // which word to push
    } t_dp_cmd;

    typedef struct packed {
        logic [3:0] word_in_block;
        logic       last_round;
    } t_dp_stat;

    localparam logic [2:0] PUSH_DATA  = 3'd0;
    localparam logic [2:0] PUSH_ZERO  = 3'd1;
    localparam logic [2:0] PUSH_LEN_H = 3'd2;
    localparam logic [2:0] PUSH_LEN_L = 3'd3;
    localparam logic [2:0] PUSH_PAD   = 3'd4;

    localparam logic [63:0] IV [8] = '{
        64'h22312194FC2BF72C, 64'h9F555FA3C84C64C2, 64'h2393B86B6F53B151,
        64'h963877195940EABD, 64'h96283EE2A88EFFE3, 64'hBE5E1E2553863992,
        64'h2B0199FC2C85B8AA, 64'h0EB72DDC81C52CA2
    };

    localparam int NUM_ROUNDS = 80;

    localparam logic [63:0] ROUND_K [NUM_ROUNDS] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

endpackage

// ===== rtl/sha_datapath.sv =====
module sha_datapath import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_req     i_req,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    output logic [63:0] o_hash [4]
);

    logic [63:0] r_h [8];
    logic [63:0] r_v [8];
    logic [63:0] r_w [16];
    logic [3:0]  r_wib;
    logic [63:0] r_bytes;
    logic [6:0]  r_round;

    logic [3:0]  nv;
    logic [63:0] mask;
    logic [63:0] pad;
    logic [63:0] data_word;
    logic [63:0] push_word;
    logic [63:0] x2, x15, s0, s1, w_new, w, t1, t2, ep1, ep0, ch, maj;

    always_comb begin
        if (!i_req.is_last || i_req.valid_bytes >= 4'd8) begin
            nv = 4'd8;
        end else begin
            nv = i_req.valid_bytes;
        end
        mask = (nv == 4'd0) ? 64'd0 : ~(64'hFFFF_FFFF_FFFF_FFFF >> {nv[2:0], 3'b000});
        pad  = 64'h8000_0000_0000_0000 >> {nv[2:0], 3'b000};
        // A full last word takes its pad in the following word.
        data_word = (i_req.is_last && nv != 4'd8) ? ((i_req.message_word & mask) | pad)
                                                  : i_req.message_word;
    end

    always_comb begin
        unique case (i_cmd.push_sel)
            PUSH_DATA:  push_word = data_word;
            PUSH_ZERO:  push_word = 64'd0;
            PUSH_LEN_H: push_word = {61'd0, r_bytes[63:61]};
            PUSH_LEN_L: push_word = {r_bytes[60:0], 3'b000};
            PUSH_PAD:   push_word = 64'h8000_0000_0000_0000;
            default:    push_word = 64'd0;
        endcase
    end

    // The schedule window is a rolling buffer indexed by round modulo 16.
    always_comb begin
        x2    = r_w[4'(r_round - 7'd2)];
        x15   = r_w[4'(r_round - 7'd15)];
        s1    = {x2[18:0], x2[63:19]} ^ {x2[60:0], x2[63:61]} ^ (x2 >> 6);
        s0    = {x15[0], x15[63:1]} ^ {x15[7:0], x15[63:8]} ^ (x15 >> 7);
        w_new = s1 + r_w[4'(r_round - 7'd7)] + s0 + r_w[r_round[3:0]];
        w     = (r_round < 7'd16) ? r_w[r_round[3:0]] : w_new;
        ep1   = {r_v[4][13:0], r_v[4][63:14]} ^ {r_v[4][17:0], r_v[4][63:18]}
              ^ {r_v[4][40:0], r_v[4][63:41]};
        ep0   = {r_v[0][27:0], r_v[0][63:28]} ^ {r_v[0][33:0], r_v[0][63:34]}
              ^ {r_v[0][38:0], r_v[0][63:39]};
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1    = r_v[7] + ep1 + ch + ROUND_K[r_round] + w;
        t2    = ep0 + maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_w[r_wib] <= push_word;
        end else if (i_cmd.round_step && r_round >= 7'd16) begin
            r_w[r_round[3:0]] <= w_new;
        end
        if (i_cmd.round_init) begin
            r_v <= r_h;
        end else if (i_cmd.round_step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.msg_clear) begin
            r_h     <= IV;
            r_wib   <= 4'd0;
            r_bytes <= 64'd0;
            r_round <= 7'd0;
        end else begin
            if (i_cmd.push) begin
                r_wib <= r_wib + 4'd1;
            end
            if (i_cmd.add_bytes) begin
                r_bytes <= r_bytes + {60'd0, nv};
            end
            if (i_cmd.round_init) begin
                r_round <= 7'd0;
            end else if (i_cmd.round_step) begin
                r_round <= r_round + 7'd1;
            end
            if (i_cmd.round_fold) begin
                for (int j = 0; j < 8; j++) begin
                    r_h[j] <= r_h[j] + r_v[j];
                end
            end
        end
    end

    assign o_stat.word_in_block = r_wib;
    assign o_stat.last_round    = (r_round == 7'(NUM_ROUNDS - 1));
    assign o_hash[0] = r_h[0];
    assign o_hash[1] = r_h[1];
    assign o_hash[2] = r_h[2];
    assign o_hash[3] = r_h[3];

endmodule

// ===== rtl/sha_ctrl.sv =====
module sha_ctrl import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_req     i_req,
    input  t_dp_stat    i_stat,
    input  logic [63:0] i_hash [4],
    output t_dp_cmd     o_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_req    o_req
);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_ROUND, S_FOLD, S_PAD80, S_ZERO, S_LENH, S_LENL, S_OUT
    } t_state;

    t_state     r_state, r_ret;
    logic [1:0] r_idx;
    logic       in_acc, full_last;

    assign o_ready   = (r_state == S_IDLE);
    assign in_acc    = i_valid && o_ready;
    assign full_last = i_req.valid_bytes >= 4'd8;
    assign o_valid   = (r_state == S_OUT);

    always_comb begin
        o_req.digest_word = i_hash[r_idx];
        o_req.word_index  = r_idx;
        o_req.digest_done = (r_idx == 2'd3);
        o_cmd = '0;
        o_cmd.push_sel = PUSH_ZERO;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.push      = in_acc;
                o_cmd.add_bytes = in_acc;
                o_cmd.push_sel  = PUSH_DATA;
            end
            S_INIT:  o_cmd.round_init = 1'b1;
            S_ROUND: o_cmd.round_step = 1'b1;
            S_FOLD:  o_cmd.round_fold = 1'b1;
            S_PAD80: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = PUSH_PAD;
            end
            S_ZERO: o_cmd.push = 1'b1;
            S_LENH: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = PUSH_LEN_H;
            end
            S_LENL: begin
                o_cmd.push     = 1'b1;
                o_cmd.push_sel = PUSH_LEN_L;
            end
            S_OUT: o_cmd.msg_clear = i_ready && r_idx == 2'd3;
            default: ;
        endcase
    end

    // After a fold the controller returns to idle, to the digest output, or to padding where it left off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_idx   <= 2'd0;
        end else begin
            unique case (r_state)
                S_IDLE: if (in_acc) begin
                    if (!i_req.is_last) begin
                        r_ret <= S_IDLE;
                    end else if (full_last) begin
                        r_ret <= S_PAD80;
                    end else begin
                        r_ret <= S_ZERO;
                    end
                    if (i_stat.word_in_block == 4'd15) begin
                        r_state <= S_INIT;
                    end else if (!i_req.is_last) begin
                        r_state <= S_IDLE;
                    end else if (full_last) begin
                        r_state <= S_PAD80;
                    end else if (i_stat.word_in_block == 4'd13) begin
                        r_state <= S_LENH;
                    end else begin
                        r_state <= S_ZERO;
                    end
                end
                S_INIT:  r_state <= S_ROUND;
                S_ROUND: if (i_stat.last_round) r_state <= S_FOLD;
                S_FOLD: begin
                    if (r_ret == S_OUT || r_ret == S_IDLE) begin
                        r_state <= r_ret;
                    end else if (r_ret == S_PAD80 || i_stat.word_in_block != 4'd14) begin
                        r_state <= r_ret;
                    end else begin
                        r_state <= S_LENH;
                    end
                end
                S_PAD80: begin
                    r_ret <= S_ZERO;
                    if (i_stat.word_in_block == 4'd15) begin
                        r_state <= S_INIT;
                    end else if (i_stat.word_in_block == 4'd13) begin
                        r_state <= S_LENH;
                    end else begin
                        r_state <= S_ZERO;
                    end
                end
                S_ZERO: begin
                    r_ret <= S_ZERO;
                    if (i_stat.word_in_block == 4'd15) begin
                        r_state <= S_INIT;
                    end else if (i_stat.word_in_block == 4'd13) begin
                        r_state <= S_LENH;
                    end else begin
                        r_state <= S_ZERO;
                    end
                end
                S_LENH: r_state <= S_LENL;
                S_LENL: begin
                    r_ret   <= S_OUT;
                    r_idx   <= 2'd0;
                    r_state <= S_INIT;
                end
                S_OUT: if (i_ready) begin
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == 2'd3) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_len_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LENH |-> i_stat.word_in_block == 4'd14)
        else $error("length pushed at wrong slot");
    a_init_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INIT |-> i_stat.word_in_block == 4'd0)
        else $error("compression started on partial block");
    a_fold_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FOLD |-> $past(r_state) == S_ROUND)
        else $error("fold without rounds");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> !o_cmd.round_step)
        else $error("push during rounds");
`endif

endmodule

// ===== rtl/sha512_256_hash_engine_core.sv =====
// SHA-512/256 engine: a 64-bit message word is taken per request; every sixteenth
// word starts an 80-round compression at one round per cycle, between a load and
// a fold, and no new word is taken until it is done. The last word triggers
// padding, the final compression (two when the length does not fit) and then
// four digest requests, most significant first; the engine then restarts for
// the next message.
module sha512_256_hash_engine_core import sha_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_req  i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_out_req o_data
);

    t_dp_cmd     cmd;
    t_dp_stat    stat;
    logic [63:0] hash [4];

    sha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_data),
        .i_stat  (stat),
        .i_hash  (hash),
        .o_cmd   (cmd),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_req   (o_data)
    );

    sha_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_data),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_hash  (hash)
    );

endmodule
